// File: hw/rtl/tce_pkg.sv
package tce_pkg;

  localparam int VID_W   = 12;
  localparam int CFG_W   = 13;
  localparam int TOTAL_W = 40;
  localparam int KEPT_W  = 15;
  localparam logic [CFG_W-1:0] VCOUNT_RESET = 13'd4096;

  typedef enum logic [4:0] {
    ST_LOAD, ST_CLR,
    ST_DG_A, ST_DG_B, ST_DG_C, ST_DG_D,
    ST_OR_A, ST_OR_B, ST_OR_C, ST_OR_D, ST_OR_E, ST_OR_F,
    ST_PS_A, ST_PS_B,
    ST_SO_A, ST_SO_B, ST_SO_C,
    ST_FL_A, ST_FL_B, ST_FL_C, ST_FL_D,
    ST_CT_A, ST_CT_B, ST_CT_C, ST_CT_D, ST_CT_E, ST_CT_F,
    ST_MG_A, ST_MG_B, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_LOAD, OP_CLR,
    OP_DG_A, OP_DG_B, OP_DG_C, OP_DG_D,
    OP_OR_A, OP_OR_B, OP_OR_C, OP_OR_D, OP_OR_E, OP_OR_F,
    OP_PS_A, OP_PS_B,
    OP_SO_A, OP_SO_B, OP_SO_C,
    OP_FL_A, OP_FL_B, OP_FL_C, OP_FL_D,
    OP_CT_A, OP_CT_B, OP_CT_C, OP_CT_D, OP_CT_E, OP_CT_F,
    OP_MG_A, OP_MG_B, OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic last_fire;
    logic sweep_last;
    logic idx_end;
    logic merge_go;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/tce_if.sv
interface tce_edge_if;
  import tce_pkg::*;
  logic             valid;
  logic             ready;
  logic [VID_W-1:0] tail_vertex;
  logic [VID_W-1:0] head_vertex;
  logic             last_edge;
  modport source (output valid, tail_vertex, head_vertex, last_edge, input ready);
  modport sink (input valid, tail_vertex, head_vertex, last_edge, output ready);
endinterface

interface tce_result_if;
  import tce_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] triangle_total;
  logic [KEPT_W-1:0]  edges_kept;
  logic               capacity_overflow;
  modport source (output valid, triangle_total, edges_kept, capacity_overflow, input ready);
  modport sink (input valid, triangle_total, edges_kept, capacity_overflow, output ready);
endinterface

// File: hw/rtl/triangle_count_engine_top.sv
// Load: one edge word per cycle while idle; the last edge starts counting.
// Count: a clear sweep, then degree, orient, prefix, sort, fill and count passes with
// merge steps; the single read port of each table sets the pace.
// One graph at a time: no edge is taken from the last edge until the result loads.
// Reset (rst, synchronous): empty edge store, vertex_count 4096, no result.
module triangle_count_engine_top
  import tce_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  tce_edge_if.sink         edge_in,
  tce_result_if.source     result_out
);
  cmd_t    cmd;
  status_t status;

  tce_ctrl u_ctrl (.clk, .rst, .status, .cmd);

  tce_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .cfg_we, .cfg_wdata, .cmd, .status, .edge_in, .result_out);
endmodule

// File: hw/rtl/tce_ram.sv
module tce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/tce_ctrl.sv
module tce_ctrl
  import tce_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (status.last_fire) state_next = ST_CLR;
      ST_CLR:  if (status.sweep_last) state_next = ST_DG_A;
      ST_DG_A: state_next = status.idx_end ? ST_OR_A : ST_DG_B;
      ST_DG_B: state_next = ST_DG_C;
      ST_DG_C: state_next = ST_DG_D;
      ST_DG_D: state_next = ST_DG_A;
      ST_OR_A: state_next = status.idx_end ? ST_PS_A : ST_OR_B;
      ST_OR_B: state_next = ST_OR_C;
      ST_OR_C: state_next = ST_OR_D;
      ST_OR_D: state_next = ST_OR_E;
      ST_OR_E: state_next = ST_OR_F;
      ST_OR_F: state_next = ST_OR_A;
      ST_PS_A: state_next = ST_PS_B;
      ST_PS_B: state_next = status.sweep_last ? ST_SO_A : ST_PS_A;
      ST_SO_A: state_next = status.idx_end ? ST_FL_A : ST_SO_B;
      ST_SO_B: state_next = ST_SO_C;
      ST_SO_C: state_next = ST_SO_A;
      ST_FL_A: state_next = status.idx_end ? ST_CT_A : ST_FL_B;
      ST_FL_B: state_next = ST_FL_C;
      ST_FL_C: state_next = ST_FL_D;
      ST_FL_D: state_next = ST_FL_A;
      ST_CT_A: state_next = status.idx_end ? ST_DONE : ST_CT_B;
      ST_CT_B: state_next = ST_CT_C;
      ST_CT_C: state_next = ST_CT_D;
      ST_CT_D: state_next = ST_CT_E;
      ST_CT_E: state_next = ST_CT_F;
      ST_CT_F: state_next = ST_MG_A;
      ST_MG_A: state_next = status.merge_go ? ST_MG_B : ST_CT_A;
      ST_MG_B: state_next = ST_MG_A;
      ST_DONE: if (status.out_free) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.in_ready = (state == ST_LOAD);
    unique case (state)
      ST_LOAD: cmd.op = OP_LOAD;
      ST_CLR:  cmd.op = OP_CLR;
      ST_DG_A: cmd.op = OP_DG_A;
      ST_DG_B: cmd.op = OP_DG_B;
      ST_DG_C: cmd.op = OP_DG_C;
      ST_DG_D: cmd.op = OP_DG_D;
      ST_OR_A: cmd.op = OP_OR_A;
      ST_OR_B: cmd.op = OP_OR_B;
      ST_OR_C: cmd.op = OP_OR_C;
      ST_OR_D: cmd.op = OP_OR_D;
      ST_OR_E: cmd.op = OP_OR_E;
      ST_OR_F: cmd.op = OP_OR_F;
      ST_PS_A: cmd.op = OP_PS_A;
      ST_PS_B: cmd.op = OP_PS_B;
      ST_SO_A: cmd.op = OP_SO_A;
      ST_SO_B: cmd.op = OP_SO_B;
      ST_SO_C: cmd.op = OP_SO_C;
      ST_FL_A: cmd.op = OP_FL_A;
      ST_FL_B: cmd.op = OP_FL_B;
      ST_FL_C: cmd.op = OP_FL_C;
      ST_FL_D: cmd.op = OP_FL_D;
      ST_CT_A: cmd.op = OP_CT_A;
      ST_CT_B: cmd.op = OP_CT_B;
      ST_CT_C: cmd.op = OP_CT_C;
      ST_CT_D: cmd.op = OP_CT_D;
      ST_CT_E: cmd.op = OP_CT_E;
      ST_CT_F: cmd.op = OP_CT_F;
      ST_MG_A: cmd.op = OP_MG_A;
      ST_MG_B: cmd.op = OP_MG_B;
      ST_DONE: cmd.op = OP_DONE;
      default: cmd.op = OP_LOAD;
    endcase
  end
endmodule

// File: hw/rtl/tce_datapath.sv
module tce_datapath
  import tce_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  cmd_t             cmd,
  output status_t          status,
  tce_edge_if.sink         edge_in,
  tce_result_if.source     result_out
);
  localparam int VIW  = $clog2(MAX_VERTICES);
  localparam int VA   = $clog2(MAX_VERTICES + 1);
  localparam int EA   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int DW   = EC_W + 1;
  localparam logic [VA-1:0]   J_LAST = VA'(MAX_VERTICES);
  localparam logic [EC_W-1:0] E_MAX  = EC_W'(MAX_EDGES);

  logic [CFG_W-1:0]   vcount;
  logic [EC_W-1:0]    e_cnt, idx, acc, pos, a0, a1, b0, b1;
  logic               ovf;
  logic [VA-1:0]      j;
  logic [VIW-1:0]     u, v;
  logic [DW-1:0]      du;
  logic [TOTAL_W-1:0] total;

  logic           et_we, eh_we, deg_we, bk_we, ls_we, fp_we, so_we, adj_we;
  logic [EA-1:0]  et_wa, e_ra, so_wa, so_ra, adj_wa, adja_ra, adjb_ra;
  logic [VIW-1:0] et_wd, eh_wd, et_rd, eh_rd, adj_wd, adja_rd, adjb_rd;
  logic [VIW-1:0] deg_wa, deg_ra, fp_wa, fp_ra;
  logic [VA-1:0]  bk_wa, bk_ra, ls_wa, ls_ra;
  logic [DW-1:0]  deg_wd, deg_rd;
  logic [EC_W-1:0] bk_wd, bk_rd, ls_wd, ls_rd, fp_wd, fp_rd;
  logic [EA-1:0]  so_wd, so_rd;

  logic in_fire, in_keep, swap, idx_end;
  logic [EC_W-1:0] acc_new;

  assign edge_in.ready = cmd.in_ready;
  assign in_fire = edge_in.valid && edge_in.ready;
  assign in_keep = (edge_in.tail_vertex != edge_in.head_vertex)
                && (CFG_W'(edge_in.tail_vertex) < vcount)
                && (CFG_W'(edge_in.head_vertex) < vcount)
                && (int'(edge_in.tail_vertex) < MAX_VERTICES)
                && (int'(edge_in.head_vertex) < MAX_VERTICES);
  assign idx_end = (idx == e_cnt);
  assign swap    = !((du < deg_rd) || ((du == deg_rd) && (u < v)));
  assign acc_new = acc + bk_rd;

  assign status.last_fire  = in_fire && edge_in.last_edge;
  assign status.sweep_last = (j == J_LAST);
  assign status.idx_end    = idx_end;
  assign status.merge_go   = (a0 < a1) && (b0 < b1);
  assign status.out_free   = !result_out.valid || result_out.ready;

  always_comb begin
    et_we = 1'b0; eh_we = 1'b0; deg_we = 1'b0; bk_we = 1'b0;
    ls_we = 1'b0; fp_we = 1'b0; so_we = 1'b0; adj_we = 1'b0;
    et_wa = e_cnt[EA-1:0]; et_wd = VIW'(edge_in.tail_vertex);
    eh_wd = VIW'(edge_in.head_vertex);
    e_ra = idx[EA-1:0];
    deg_wa = u; deg_wd = deg_rd + DW'(1); deg_ra = et_rd;
    bk_wa = VA'(v) + VA'(1); bk_wd = bk_rd + EC_W'(1); bk_ra = VA'(v) + VA'(1);
    ls_wa = VA'(u); ls_wd = ls_rd + EC_W'(1); ls_ra = VA'(u);
    fp_wa = u; fp_wd = fp_rd + EC_W'(1); fp_ra = et_rd;
    so_wa = bk_rd[EA-1:0]; so_wd = idx[EA-1:0]; so_ra = idx[EA-1:0];
    adj_wa = fp_rd[EA-1:0]; adj_wd = v;
    adja_ra = a0[EA-1:0]; adjb_ra = b0[EA-1:0];
    unique case (cmd.op)
      OP_LOAD: begin
        et_we = in_fire && in_keep && (e_cnt != E_MAX);
        eh_we = in_fire && in_keep && (e_cnt != E_MAX);
      end
      OP_CLR: begin
        deg_we = (j != J_LAST); deg_wa = VIW'(j); deg_wd = '0;
        bk_we = 1'b1; bk_wa = j; bk_wd = '0;
        ls_we = 1'b1; ls_wa = j; ls_wd = '0;
      end
      OP_DG_B: deg_ra = et_rd;
      OP_DG_C: begin
        deg_we = 1'b1; deg_wa = u; deg_ra = v;
      end
      OP_DG_D: begin
        deg_we = 1'b1; deg_wa = v;
      end
      OP_OR_B: deg_ra = et_rd;
      OP_OR_C: deg_ra = v;
      OP_OR_D: begin
        et_we = 1'b1; eh_we = 1'b1; et_wa = idx[EA-1:0];
        et_wd = swap ? v : u; eh_wd = swap ? u : v;
      end
      OP_OR_E: begin
        bk_ra = VA'(v) + VA'(1); ls_ra = VA'(u);
      end
      OP_OR_F: begin
        bk_we = 1'b1; ls_we = 1'b1;
      end
      OP_PS_A: begin
        bk_ra = j; ls_ra = j;
      end
      OP_PS_B: begin
        bk_we = 1'b1; bk_wa = j; bk_wd = acc_new;
        ls_we = 1'b1; ls_wa = j; ls_wd = pos;
        fp_we = (j != J_LAST); fp_wa = VIW'(j); fp_wd = pos;
      end
      OP_SO_B: bk_ra = VA'(eh_rd);
      OP_SO_C: begin
        so_we = 1'b1; bk_we = 1'b1; bk_wa = VA'(v);
      end
      OP_FL_B: e_ra = so_rd;
      OP_FL_C: fp_ra = et_rd;
      OP_FL_D: begin
        adj_we = 1'b1; fp_we = 1'b1;
      end
      OP_CT_B: ls_ra = VA'(et_rd);
      OP_CT_C: ls_ra = VA'(u) + VA'(1);
      OP_CT_D: ls_ra = VA'(v);
      OP_CT_E: ls_ra = VA'(v) + VA'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RESET;
      e_cnt <= '0;
      ovf <= 1'b0;
      idx <= '0;
      j <= '0;
      total <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (cfg_we) vcount <= cfg_wdata;
      if (cmd.op == OP_DONE && status.out_free) result_out.valid <= 1'b1;
      else if (result_out.valid && result_out.ready) result_out.valid <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          idx <= '0; j <= '0; acc <= '0; pos <= '0;
          if (in_fire && in_keep) begin
            if (e_cnt != E_MAX) e_cnt <= e_cnt + EC_W'(1);
            else ovf <= 1'b1;
          end
        end
        OP_CLR, OP_PS_B: begin
          j <= status.sweep_last ? '0 : j + VA'(1);
          if (cmd.op == OP_PS_B) begin
            acc <= acc_new;
            pos <= pos + ls_rd;
          end
        end
        OP_DG_A, OP_OR_A, OP_SO_A, OP_FL_A, OP_CT_A: if (idx_end) idx <= '0;
        OP_DG_B, OP_OR_B, OP_FL_C, OP_CT_B: begin
          u <= et_rd; v <= eh_rd;
        end
        OP_OR_C: du <= deg_rd;
        OP_OR_D: if (swap) begin
          u <= v; v <= u;
        end
        OP_SO_B: v <= eh_rd;
        OP_DG_D, OP_OR_F, OP_SO_C, OP_FL_D: idx <= idx + EC_W'(1);
        OP_CT_C: a0 <= ls_rd;
        OP_CT_D: a1 <= ls_rd;
        OP_CT_E: b0 <= ls_rd;
        OP_CT_F: begin
          b1 <= ls_rd; idx <= idx + EC_W'(1);
        end
        OP_MG_B: begin
          if (adja_rd == adjb_rd) begin
            if (total != '1) total <= total + TOTAL_W'(1);
            a0 <= a0 + EC_W'(1); b0 <= b0 + EC_W'(1);
          end else if (adja_rd < adjb_rd) begin
            a0 <= a0 + EC_W'(1);
          end else begin
            b0 <= b0 + EC_W'(1);
          end
        end
        OP_DONE: if (status.out_free) begin
          result_out.triangle_total <= total;
          result_out.edges_kept <= KEPT_W'(e_cnt);
          result_out.capacity_overflow <= ovf;
          total <= '0; e_cnt <= '0; ovf <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  tce_ram #(.WIDTH(VIW), .DEPTH(MAX_EDGES)) u_et (
    .clk, .we(et_we), .waddr(et_wa), .wdata(et_wd), .raddr(e_ra), .rdata(et_rd));
  tce_ram #(.WIDTH(VIW), .DEPTH(MAX_EDGES)) u_eh (
    .clk, .we(eh_we), .waddr(et_wa), .wdata(eh_wd), .raddr(e_ra), .rdata(eh_rd));
  tce_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg (
    .clk, .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd));
  tce_ram #(.WIDTH(EC_W), .DEPTH(MAX_VERTICES + 1)) u_bk (
    .clk, .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));
  tce_ram #(.WIDTH(EC_W), .DEPTH(MAX_VERTICES + 1)) u_ls (
    .clk, .we(ls_we), .waddr(ls_wa), .wdata(ls_wd), .raddr(ls_ra), .rdata(ls_rd));
  tce_ram #(.WIDTH(EC_W), .DEPTH(MAX_VERTICES)) u_fp (
    .clk, .we(fp_we), .waddr(fp_wa), .wdata(fp_wd), .raddr(fp_ra), .rdata(fp_rd));
  tce_ram #(.WIDTH(EA), .DEPTH(MAX_EDGES)) u_so (
    .clk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
  tce_ram #(.WIDTH(VIW), .DEPTH(MAX_EDGES)) u_adja (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adja_ra), .rdata(adja_rd));
  tce_ram #(.WIDTH(VIW), .DEPTH(MAX_EDGES)) u_adjb (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adjb_ra), .rdata(adjb_rd));

`ifndef SYNTH
  a_ecnt_bound: assert property (@(posedge clk) disable iff (rst) e_cnt <= E_MAX)
    else $error("edge count above capacity");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst) ovf |-> e_cnt == E_MAX)
    else $error("overflow flagged with room left");
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst) j <= J_LAST)
    else $error("sweep index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.ready) |=> $stable(result_out.triangle_total))
    else $error("pending result overwritten");
`endif
endmodule
